@@ hw/rtl/ipsd_pkg.sv @@
`default_nettype none

package ipsd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int HEADER_LEN = 5;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_LITERAL = 2'd2;
    localparam logic [1:0] KIND_RUN     = 2'd3;

    // One pending result, before the address add.
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] offset;
        logic [15:0] index;
        logic [15:0] length;
        logic [7:0]  value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Expected header text "PATCH", one character per position.
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = 8'h50;
            3'd1: ch = 8'h41;
            3'd2: ch = 8'h54;
            3'd3: ch = 8'h43;
            3'd4: ch = 8'h48;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ipsd_parser.sv @@
`default_nettype none

module ipsd_parser
    import ipsd_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,     // stream_byte
    input  wire queue_status_t q_status,
    output logic               push,
    output cmd_t               push_cmd
);

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_OFFSET   = 7'b0000010,
        PH_SIZE     = 7'b0000100,
        PH_LITERAL  = 7'b0001000,
        PH_RUNCOUNT = 7'b0010000,
        PH_RUNFILL  = 7'b0100000,
        PH_REJECTED = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] counter_reg, counter_next;
    logic [23:0] offset_reg, offset_next;
    logic [15:0] size_reg, size_next;
    logic        mismatch_reg, mismatch_next;

    logic        accept;
    logic [16:0] cnt_inc;
    logic        hdr_bad;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign cnt_inc  = {1'b0, counter_reg} + 17'd1;
    assign hdr_bad  = mismatch_reg || (s_tdata != header_char(counter_reg[2:0]));

    always_comb begin
        phase_next    = phase_reg;
        counter_next  = counter_reg;
        offset_next   = offset_reg;
        size_next     = size_reg;
        mismatch_next = mismatch_reg;
        push          = 1'b0;
        push_cmd      = '0;
        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    mismatch_next = hdr_bad;
                    counter_next  = cnt_inc[15:0];
                    if (cnt_inc >= 17'(HEADER_LEN)) begin
                        counter_next  = '0;
                        push          = 1'b1;
                        push_cmd.kind = hdr_bad ? KIND_REJECT : KIND_ACCEPT;
                        phase_next    = hdr_bad ? PH_REJECTED : PH_OFFSET;
                    end
                end
                PH_OFFSET: begin
                    offset_next  = {offset_reg[15:0], s_tdata};
                    counter_next = cnt_inc[15:0];
                    if (cnt_inc >= 17'd3) begin
                        counter_next = '0;
                        size_next    = '0;
                        phase_next   = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    size_next    = {size_reg[7:0], s_tdata};
                    counter_next = cnt_inc[15:0];
                    if (cnt_inc >= 17'd2) begin
                        counter_next = '0;
                        phase_next   = (size_next != '0) ? PH_LITERAL : PH_RUNCOUNT;
                    end
                end
                PH_LITERAL: begin
                    push            = 1'b1;
                    push_cmd.kind   = KIND_LITERAL;
                    push_cmd.offset = offset_reg;
                    push_cmd.index  = counter_reg;
                    push_cmd.length = 16'd1;
                    push_cmd.value  = s_tdata;
                    counter_next    = cnt_inc[15:0];
                    if (cnt_inc >= {1'b0, size_reg}) begin
                        counter_next = '0;
                        offset_next  = '0;
                        phase_next   = PH_OFFSET;
                    end
                end
                PH_RUNCOUNT: begin
                    size_next    = {size_reg[7:0], s_tdata};
                    counter_next = cnt_inc[15:0];
                    if (cnt_inc >= 17'd2) begin
                        counter_next = '0;
                        phase_next   = PH_RUNFILL;
                    end
                end
                PH_RUNFILL: begin
                    push            = 1'b1;
                    push_cmd.kind   = KIND_RUN;
                    push_cmd.offset = offset_reg;
                    push_cmd.length = size_reg;
                    push_cmd.value  = s_tdata;
                    counter_next    = '0;
                    offset_next     = '0;
                    phase_next      = PH_OFFSET;
                end
                default: begin
                    // rejected header: drop everything until reset
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            counter_reg  <= '0;
            offset_reg   <= '0;
            size_reg     <= '0;
            mismatch_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            counter_reg  <= counter_next;
            offset_reg   <= offset_next;
            size_reg     <= size_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ipsd_queue.sv @@
`default_nettype none

module ipsd_queue
    import ipsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire cmd_t     push_cmd,
    input  wire logic     pop,
    output cmd_t          head_cmd,
    output queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count not reduced by pop");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ipsd_emitter.sv @@
`default_nettype none

module ipsd_emitter
    import ipsd_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire queue_status_t q_status,
    input  wire cmd_t          head_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [55:0]        m_tdata,    // target_address, run_length, byte_value
    output logic [1:0]         m_tuser     // result_kind
);

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [24:0] addr_reg;
    logic [15:0] len_reg;
    logic [7:0]  value_reg;

    // advance whenever the output register is empty or being drained
    assign pop = !q_status.empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg  <= head_cmd.kind;
            addr_reg  <= {1'b0, head_cmd.offset} + {9'd0, head_cmd.index};
            len_reg   <= head_cmd.length;
            value_reg <= head_cmd.value;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {7'd0, value_reg, len_reg, addr_reg};

endmodule

`default_nettype wire

@@ hw/rtl/ips_patch_stream_decoder_top.sv @@
`default_nettype none

// IPS patch stream decoder. Feed the patch file one byte per transfer on the
// s_ channel; the block checks the "PATCH" header, reports accept or reject,
// then turns each record into results on the m_ channel: one literal write
// per data byte (address = offset + index, length 1) or one run descriptor
// per RLE record. After a rejected header every byte is taken and dropped
// until reset; the "EOF" marker is parsed as an ordinary record offset.
// Throughput is one byte per cycle while the queue has room: the parser
// updates its phase and hands results through a QUEUE_DEPTH-entry queue to an
// output register that forms the address, so a result passes through a queue
// entry and then the output register. s_tready drops only while the queue is
// full, which happens after QUEUE_DEPTH results wait behind a stalled m_ side.
// No clearing pass is needed after reset.
module ips_patch_stream_decoder_top
    import ipsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // stream_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,    // target_address[24:0], run_length[40:25],
                                         // byte_value[48:41], zero fill
    output logic [1:0]       m_tuser     // result_kind
);

    queue_status_t q_status;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head_cmd;

    ipsd_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ipsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    ipsd_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
    import ipsd_pkg::*;
();

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          RANDOM_BYTES = 440;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam logic [39:0] MAGIC_TEXT = "PATCH";

    typedef enum logic [6:0] {
        PH_HEADER    = 7'b0000001,
        PH_OFFSET    = 7'b0000010,
        PH_SIZE      = 7'b0000100,
        PH_LITERAL   = 7'b0001000,
        PH_RUN_COUNT = 7'b0010000,
        PH_RUN_FILL  = 7'b0100000,
        PH_REJECTED  = 7'b1000000
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [24:0] addr;
        logic [15:0] len;
        logic [7:0]  val;
    } patch_result_t;

    typedef struct {
        logic [7:0]    stream_byte;
        bit            typed;
        patch_result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // decoder image, reset values
    parse_phase_t pr_phase = PH_HEADER;
    logic [15:0]  pr_count = 16'd0;
    logic [23:0]  pr_offset = 24'd0;
    logic [15:0]  pr_size = 16'd0;
    logic         pr_mismatch = 1'b0;

    patch_result_t pending_writes[$];
    dir_row_t      dir_tab[$];
    int            fail_cnt = 0;
    int            bytes_fed = 0;
    int            cycle_cnt = 0;
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;

    ips_patch_stream_decoder_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic decode_patch_byte(input logic [7:0] b, output bit has,
                                     output patch_result_t r);
        has = 1'b0;
        r   = '0;
        case (pr_phase)
            PH_HEADER: begin
                if (pr_count < HEADER_LEN && b != MAGIC_TEXT[39 - 8 * pr_count -: 8])
                    pr_mismatch = 1'b1;
                pr_count = pr_count + 16'd1;
                if (pr_count >= HEADER_LEN) begin
                    pr_count = 16'd0;
                    has      = 1'b1;
                    r.kind   = pr_mismatch ? KIND_REJECT : KIND_ACCEPT;
                    pr_phase = pr_mismatch ? PH_REJECTED : PH_OFFSET;
                end
            end
            PH_OFFSET: begin
                pr_offset = {pr_offset[15:0], b};
                pr_count  = pr_count + 16'd1;
                if (pr_count >= 16'd3) begin
                    pr_count = 16'd0;
                    pr_size  = 16'd0;
                    pr_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                pr_size  = {pr_size[7:0], b};
                pr_count = pr_count + 16'd1;
                if (pr_count >= 16'd2) begin
                    pr_count = 16'd0;
                    pr_phase = (pr_size != 16'd0) ? PH_LITERAL : PH_RUN_COUNT;
                end
            end
            PH_LITERAL: begin
                has      = 1'b1;
                r.kind   = KIND_LITERAL;
                r.addr   = {1'b0, pr_offset} + {9'd0, pr_count};
                r.len    = 16'd1;
                r.val    = b;
                pr_count = pr_count + 16'd1;
                if (pr_count >= pr_size) begin
                    pr_count  = 16'd0;
                    pr_offset = 24'd0;
                    pr_phase  = PH_OFFSET;
                end
            end
            PH_RUN_COUNT: begin
                pr_size  = {pr_size[7:0], b};
                pr_count = pr_count + 16'd1;
                if (pr_count >= 16'd2) begin
                    pr_count = 16'd0;
                    pr_phase = PH_RUN_FILL;
                end
            end
            PH_RUN_FILL: begin
                has       = 1'b1;
                r.kind    = KIND_RUN;
                r.addr    = {1'b0, pr_offset};
                r.len     = pr_size;
                r.val     = b;
                pr_count  = 16'd0;
                pr_offset = 24'd0;
                pr_phase  = PH_OFFSET;
            end
            default: ;  // rejected or unused phase: drop the byte
        endcase
    endtask

    // Offer one byte; valid stays high across back-to-back transfers.
    task automatic feed_byte(input logic [7:0] b, input bit typed,
                             input patch_result_t typed_res);
        patch_result_t pred;
        bit            has;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_fed++;
        decode_patch_byte(b, has, pred);
        if (has)
            pending_writes.push_back(typed ? typed_res : pred);
    endtask

    task automatic feed_plain(input logic [7:0] b);
        feed_byte(b, 1'b0, '0);
    endtask

    task automatic feed_literal_rec(input logic [23:0] off, input logic [15:0] size);
        feed_plain(off[23:16]);
        feed_plain(off[15:8]);
        feed_plain(off[7:0]);
        feed_plain(size[15:8]);
        feed_plain(size[7:0]);
        for (int i = 0; i < size; i++)
            feed_plain(8'($urandom_range(0, 255)));
    endtask

    task automatic feed_run_rec(input logic [23:0] off, input logic [15:0] count,
                                input logic [7:0] fill);
        feed_plain(off[23:16]);
        feed_plain(off[15:8]);
        feed_plain(off[7:0]);
        feed_plain(8'h00);
        feed_plain(8'h00);
        feed_plain(count[15:8]);
        feed_plain(count[7:0]);
        feed_plain(fill);
    endtask

    task automatic put(input logic [7:0] b);
        dir_row_t row;
        row.stream_byte = b;
        row.typed       = 1'b0;
        row.res         = '0;
        dir_tab.push_back(row);
    endtask

    task automatic put_chk(input logic [7:0] b, input logic [1:0] kind,
                           input logic [24:0] addr, input logic [15:0] len,
                           input logic [7:0] val);
        dir_row_t row;
        row.stream_byte = b;
        row.typed       = 1'b1;
        row.res         = '{kind, addr, len, val};
        dir_tab.push_back(row);
    endtask

    function automatic logic [23:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Sender: directed table, random records, then a final burst with no idling.
    initial begin
        int sel;
        // header, accepted on its last byte
        put(8'h50); put(8'h41); put(8'h54); put(8'h43);
        put_chk(8'h48, KIND_ACCEPT, 25'd0, 16'd0, 8'h00);
        // literal record at the top offset, address carries into bit 24
        put(8'hFF); put(8'hFF); put(8'hFF); put(8'h00); put(8'h02);
        put_chk(8'hFF, KIND_LITERAL, 25'h0FFFFFF, 16'd1, 8'hFF);
        put_chk(8'h80, KIND_LITERAL, 25'h1000000, 16'd1, 8'h80);
        // run record with a zero count still reports
        put(8'h00); put(8'h00); put(8'h00); put(8'h00); put(8'h00);
        put(8'h00); put(8'h00);
        put_chk(8'h00, KIND_RUN, 25'd0, 16'd0, 8'h00);
        // "EOF" taken as an offset, run of maximal count
        put(8'h45); put(8'h4F); put(8'h46); put(8'h00); put(8'h00);
        put(8'hFF); put(8'hFF);
        put_chk(8'h5A, KIND_RUN, 25'h0454F46, 16'hFFFF, 8'h5A);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            feed_byte(dir_tab[i].stream_byte, dir_tab[i].typed, dir_tab[i].res);

        hold_req = 1'b1;
        while (bytes_fed < dir_tab.size() + RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (sel < 6)
                feed_literal_rec(pick_offset(), 16'($urandom_range(1, 8)));
            else if (sel < 7)
                feed_literal_rec(pick_offset(), 16'($urandom_range(9, 64)));
            else
                feed_run_rec(pick_offset(), pick_count(), 8'($urandom_range(0, 255)));
        end

        idle_on = 1'b0;
        feed_literal_rec(24'hFFFFFF, 16'd24);
        feed_run_rec(24'hFFFFFF, 16'hFFFF, 8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (pending_writes.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && pending_writes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off to back up the queue.
    initial begin
        int hold_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_OFF_CYCLES) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        patch_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind=%0d tdata=%h",
                         $time, m_tuser, m_tdata);
                fail_cnt++;
            end else begin
                want = pending_writes.pop_front();
                if (m_tuser !== want.kind || m_tdata[24:0] !== want.addr ||
                    m_tdata[40:25] !== want.len || m_tdata[48:41] !== want.val ||
                    m_tdata[55:49] !== 7'd0) begin
                    $display("%0t: mismatch: expected kind=%0d addr=%h len=%h val=%h,",
                             $time, want.kind, want.addr, want.len, want.val,
                             " actual kind=%0d addr=%h len=%h val=%h fill=%h",
                             m_tuser, m_tdata[24:0], m_tdata[40:25], m_tdata[48:41],
                             m_tdata[55:49]);
                    fail_cnt++;
                end
            end
        end
    end

endmodule
